// ----- design/upq_pkg.sv -----
// Package for the unsorted priority queue: sizing constants, operation and
// status codes, and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package upq_pkg;

    // Sizing of the entry store.
    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;

    // Only the low VALUE_BITS bits of a value are kept, and never more than the port carries.
    localparam int STORE_VALUE_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int PRIO_BITS        = 32;
    localparam int WORD_BITS        = STORE_VALUE_BITS + PRIO_BITS;
    localparam int ADDR_W           = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W            = $clog2(CAPACITY + 1);

    // Operation codes; the fourth code is a no-op.
    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_POP      = 2'd1;
    localparam logic [1:0] OP_CONTAINS = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the accepted item and restart the walk
        logic scan_step;   // one step of the compare walk
        logic shift_init;  // start the close-up walk behind the popped entry
        logic shift_step;  // one step of the close-up walk
        logic commit;      // update the count and load the result register
    } upq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;   // operation reads the stored entries
        logic pop_live;    // pop on a non-empty queue
        logic walk_done;   // no read in flight and no entry left to read
        logic out_free;    // result register can take a new result
    } upq_stat_t;

endpackage

`default_nettype wire

// ----- design/upq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module upq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- design/upq_datapath.sv -----
// Datapath of the unsorted priority queue: entry RAM, entry count, walk
// counters, best-entry and match registers, and the result register.
// Depends on upq_pkg and upq_ram.
`default_nettype none

module upq_datapath
    import upq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire upq_cmd_t           cmd,
    output upq_stat_t               stat,
    input  wire logic [1:0]         op,
    input  wire logic [31:0]        item_value,
    input  wire logic signed [31:0] item_priority,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             popped_value,
    output logic signed [31:0]      popped_priority,
    output logic                    found,
    output logic                    now_empty,
    output logic [1:0]              status
);

    // Latched item.
    logic [1:0]                  op_reg;
    logic [STORE_VALUE_BITS-1:0] val_reg;
    logic signed [31:0]          prio_reg;

    // Entry count and walk state.
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [ADDR_W-1:0] cmp_idx_reg;
    logic              cmp_valid_reg;

    // Best entry so far and match flag.
    logic                        best_valid_reg;
    logic [ADDR_W-1:0]           best_idx_reg;
    logic [STORE_VALUE_BITS-1:0] best_val_reg;
    logic signed [31:0]          best_prio_reg;
    logic                        found_reg;

    // Result register.
    logic                        out_valid_reg;
    logic [31:0]                 res_value_reg;
    logic signed [31:0]          res_prio_reg;
    logic                        res_found_reg;
    logic                        res_empty_reg;
    logic [1:0]                  res_status_reg;

    // RAM ports.
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [WORD_BITS-1:0]        ram_wdata;
    logic [WORD_BITS-1:0]        ram_rdata;
    logic [STORE_VALUE_BITS-1:0] rd_val;
    logic signed [31:0]          rd_prio;

    logic             scan_lt;
    logic             is_full;
    logic             queue_empty;
    logic             walk_step;
    logic             shift_wr;
    logic             insert_wr;
    logic             better;
    logic             match;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       status_next;

    upq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Decode of the read word and of the walk position.
    assign rd_val      = ram_rdata[WORD_BITS-1:PRIO_BITS];
    assign rd_prio     = $signed(ram_rdata[PRIO_BITS-1:0]);
    assign scan_lt     = (scan_idx_reg < count_reg);
    assign is_full     = (count_reg >= CNT_W'(CAPACITY));
    assign queue_empty = (count_reg == '0);
    assign walk_step   = cmd.scan_step | cmd.shift_step;

    // Ties go to the newer entry, so an equal priority replaces the best.
    assign better = !best_valid_reg || (rd_prio <= best_prio_reg);
    assign match  = (rd_val == val_reg) && (rd_prio == prio_reg);

    // Write port: close-up moves an entry one slot toward the oldest end, insert appends.
    assign shift_wr  = cmd.shift_step && cmp_valid_reg;
    assign insert_wr = cmd.commit && (op_reg == OP_INSERT) && !is_full;
    assign ram_we    = shift_wr || insert_wr;
    always_comb
    begin
        if (shift_wr)
        begin
            ram_waddr = ADDR_W'(cmp_idx_reg - ADDR_W'(1));
            ram_wdata = ram_rdata;
        end
        else
        begin
            ram_waddr = count_reg[ADDR_W-1:0];
            ram_wdata = {val_reg, prio_reg};
        end
    end

    // Count and status for the operation being committed.
    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        case (op_reg)
            OP_INSERT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP:
            begin
                if (queue_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            op_reg         <= OP_INSERT;
        end
        else
        begin
            if (cmd.capture)
            begin
                op_reg         <= op;
                scan_idx_reg   <= '0;
                cmp_valid_reg  <= 1'b0;
                best_valid_reg <= 1'b0;
                found_reg      <= 1'b0;
            end
            else if (cmd.shift_init)
            begin
                scan_idx_reg  <= CNT_W'(best_idx_reg) + CNT_W'(1);
                cmp_valid_reg <= 1'b0;
            end
            else if (walk_step)
            begin
                cmp_valid_reg <= scan_lt;
                if (scan_lt)
                begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
                if (cmd.scan_step && cmp_valid_reg)
                begin
                    if (op_reg == OP_POP && better)
                    begin
                        best_valid_reg <= 1'b1;
                    end
                    if (op_reg == OP_CONTAINS && match)
                    begin
                        found_reg <= 1'b1;
                    end
                end
            end

            if (cmd.commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            val_reg  <= item_value[STORE_VALUE_BITS-1:0];
            prio_reg <= item_priority;
        end
        if (walk_step)
        begin
            cmp_idx_reg <= scan_idx_reg[ADDR_W-1:0];
        end
        if (cmd.scan_step && cmp_valid_reg && op_reg == OP_POP && better)
        begin
            best_idx_reg  <= cmp_idx_reg;
            best_val_reg  <= rd_val;
            best_prio_reg <= rd_prio;
        end
        if (cmd.commit)
        begin
            res_status_reg <= status_next;
            res_empty_reg  <= (count_next == '0);
            res_found_reg  <= (op_reg == OP_CONTAINS) && found_reg;
            if (op_reg == OP_POP && !queue_empty)
            begin
                res_value_reg <= 32'(best_val_reg);
                res_prio_reg  <= best_prio_reg;
            end
            else
            begin
                res_value_reg <= '0;
                res_prio_reg  <= '0;
            end
        end
    end

    // Status toward the controller.
    assign stat.need_scan = (op_reg == OP_POP) || (op_reg == OP_CONTAINS);
    assign stat.pop_live  = (op_reg == OP_POP) && !queue_empty;
    assign stat.walk_done = !scan_lt && !cmp_valid_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign popped_value    = res_value_reg;
    assign popped_priority = res_prio_reg;
    assign found           = res_found_reg;
    assign now_empty       = res_empty_reg;
    assign status          = res_status_reg;

    // The entry count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A close-up write lands inside the stored range.
    assert property (@(posedge clk) disable iff (!rst_n)
        shift_wr |-> (CNT_W'(cmp_idx_reg) < count_reg))
        else $error("close-up write outside stored entries");

    // A result is only loaded when the previous one has left.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // A successful pop removes exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && op_reg == OP_POP && !queue_empty)
            |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not remove one entry");

endmodule

`default_nettype wire

// ----- design/upq_controller.sv -----
// Controller state machine of the unsorted priority queue: sequences capture,
// compare walk, close-up walk and commit of one item at a time.
// Depends on upq_pkg.
`default_nettype none

module upq_controller
    import upq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire upq_stat_t stat,
    output upq_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.capture   = 1'b1;
                    in_ready_next = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!stat.need_scan)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.walk_done)
                begin
                    if (stat.pop_live)
                    begin
                        cmd.shift_init = 1'b1;
                        state_next     = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (stat.walk_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit    = 1'b1;
                    in_ready_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

`default_nettype wire

// ----- design/unsorted_priority_queue_core.sv -----
// Top level of the unsorted priority queue: controller and datapath.
// Depends on upq_pkg, upq_controller and upq_datapath.
//
// Usage: one input channel (in_valid/in_ready) carries an operation with a
// value and a signed priority; one output channel (out_valid/out_ready)
// returns exactly one result per input transfer, in order.
// Insert appends an entry; pop removes the entry with the smallest priority,
// the newest one on a tie; contains reports an exact value and priority match.
// Items are handled one at a time. Insert, no-op and any operation on an
// empty queue go straight to the commit; contains first walks every stored
// entry, and pop walks every stored entry and then closes up the entries
// that sit behind the removed one. in_ready returns with the result.
// The pace is set by the single read port of the entry RAM: the compare
// walk reads one entry per cycle, and pop then moves every entry behind the
// removed one down by one slot, one per cycle.
// A finished result sits in an output register; when the receiver stalls the
// block still takes the next item and works on it, and holds back only its
// commit until the waiting result has been transferred.
// Reset empties the queue at once; entry contents need no clearing pass.
`default_nettype none

module unsorted_priority_queue_core
    import upq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         op,
    input  wire logic [31:0]        item_value,
    input  wire logic signed [31:0] item_priority,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             popped_value,
    output logic signed [31:0]      popped_priority,
    output logic                    found,
    output logic                    now_empty,
    output logic [1:0]              status
);

    upq_cmd_t  cmd;
    upq_stat_t stat;

    upq_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    upq_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .op              (op),
        .item_value      (item_value),
        .item_priority   (item_priority),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .popped_value    (popped_value),
        .popped_priority (popped_priority),
        .found           (found),
        .now_empty       (now_empty),
        .status          (status)
    );

endmodule

`default_nettype wire

// ----- tb/tb_unsorted_priority_queue_core.sv -----
// Self-checking testbench for unsorted_priority_queue_core: directed and random
// insert, pop-minimum and contains traffic, checked by a scoreboard with its own queue model.
// Depends on upq_pkg and the unsorted_priority_queue_core RTL.
`timescale 1ns / 100ps

module tb_unsorted_priority_queue_core;
    import upq_pkg::*;

    // The fourth operation code does nothing.
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam int TOTAL_ITEMS   = 1350;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 16;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [31:0] VALUE_MASK =
        (STORE_VALUE_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << STORE_VALUE_BITS) - 32'd1);
    localparam logic signed [31:0] PRIO_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] PRIO_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [31:0]        value;
        logic signed [31:0] prio;
        logic               found;
        logic               now_empty;
        logic [1:0]         status;
    } pq_result_t;

    typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_kind_t;

    // Scoreboard: keeps its own copy of the entry list and the results still owed.
    class min_queue_scoreboard;
        logic [31:0]        stored_values [CAPACITY];
        logic signed [31:0] stored_prios  [CAPACITY];
        int                 stored_count;
        pq_result_t         owed_results[$];
        int                 failures;
        int                 n_insert, n_full, n_pop, n_empty_pop, n_contains, n_hits, n_nop;

        function new();
            stored_count = 0;
            failures     = 0;
            n_insert = 0; n_full = 0; n_pop = 0; n_empty_pop = 0;
            n_contains = 0; n_hits = 0; n_nop = 0;
        endfunction

        function int owed_count();
            return owed_results.size();
        endfunction

        // Apply one accepted operation to the model and queue the result it owes.
        function void note_request(logic [1:0] code, logic [31:0] value,
                                   logic signed [31:0] prio);
            pq_result_t  res;
            logic [31:0] key;
            int          best;
            key           = value & VALUE_MASK;
            res.value     = '0;
            res.prio      = '0;
            res.found     = 1'b0;
            res.status    = ST_OK;
            case (code)
                OP_INSERT:
                begin
                    n_insert++;
                    if (stored_count >= CAPACITY)
                    begin
                        res.status = ST_FULL;
                        n_full++;
                    end
                    else
                    begin
                        stored_values[stored_count] = key;
                        stored_prios[stored_count]  = prio;
                        stored_count++;
                    end
                end
                OP_POP:
                begin
                    n_pop++;
                    if (stored_count == 0)
                    begin
                        res.status = ST_EMPTY;
                        n_empty_pop++;
                    end
                    else
                    begin
                        // Oldest to newest with <= so that the newest tie wins.
                        best = 0;
                        for (int i = 1; i < stored_count; i++)
                            if (stored_prios[i] <= stored_prios[best])
                                best = i;
                        res.value = stored_values[best];
                        res.prio  = stored_prios[best];
                        for (int i = best; i + 1 < stored_count; i++)
                        begin
                            stored_values[i] = stored_values[i + 1];
                            stored_prios[i]  = stored_prios[i + 1];
                        end
                        stored_count--;
                    end
                end
                OP_CONTAINS:
                begin
                    n_contains++;
                    for (int i = 0; i < stored_count; i++)
                        if (stored_values[i] == key && stored_prios[i] == prio)
                            res.found = 1'b1;
                    if (res.found)
                        n_hits++;
                end
                default:
                    n_nop++;
            endcase
            res.now_empty = (stored_count == 0);
            owed_results.push_back(res);
        endfunction

        // Compare one result transfer with the oldest owed result.
        function void check_result(pq_result_t got);
            pq_result_t want;
            if (owed_results.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("ERROR: result transfer with none outstanding: value=%h prio=%0d",
                             got.value, got.prio);
                return;
            end
            want = owed_results.pop_front();
            if (got.value !== want.value || got.prio !== want.prio ||
                got.found !== want.found || got.now_empty !== want.now_empty ||
                got.status !== want.status)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("ERROR: result mismatch at %0t", $time);
                    $display("  expected value=%h prio=%0d found=%b empty=%b status=%0d",
                             want.value, want.prio, want.found, want.now_empty, want.status);
                    $display("  actual   value=%h prio=%0d found=%b empty=%b status=%0d",
                             got.value, got.prio, got.found, got.now_empty, got.status);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic [31:0]        item_value;
    logic signed [31:0] item_priority;
    logic               out_valid;
    logic               out_ready;
    logic [31:0]        popped_value;
    logic signed [31:0] popped_priority;
    logic               found;
    logic               now_empty;
    logic [1:0]         status;

    min_queue_scoreboard board;
    int                  items_sent;
    int                  tx_idle_pct;
    int                  rx_idle_pct;
    int                  cycle_count;

    unsorted_priority_queue_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .item_value      (item_value),
        .item_priority   (item_priority),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .popped_value    (popped_value),
        .popped_priority (popped_priority),
        .found           (found),
        .now_empty       (now_empty),
        .status          (status)
    );

    // 10 ns clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: ready is redrawn every falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    // Result monitor.
    always @(posedge clk)
    begin
        pq_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.value     = popped_value;
            got.prio      = popped_priority;
            got.found     = found;
            got.now_empty = now_empty;
            got.status    = status;
            board.check_result(got);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, board.owed_count());
            $display("** unsorted_priority_queue_core: FAILED **");
            $finish;
        end
    end

    // Idle rates follow the thirds of the run.
    function void update_idle_rates();
        if (items_sent < TOTAL_ITEMS / 3)
        begin
            tx_idle_pct = 24;
            rx_idle_pct = 78;
        end
        else if (items_sent < 2 * TOTAL_ITEMS / 3)
        begin
            tx_idle_pct = 78;
            rx_idle_pct = 24;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endfunction

    // Present one operation, after a random idle gap, and hold it until the transfer.
    task automatic send_op(logic [1:0] code, logic [31:0] value, logic signed [31:0] prio);
        update_idle_rates();
        while ($urandom_range(99, 0) < tx_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        op            <= code;
        item_value    <= value;
        item_priority <= prio;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(code, value, prio);
        items_sent++;
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.owed_count() != 0)
            @(posedge clk);
    endtask

    // Priorities cluster on a few values so that ties and exact hits are common.
    function automatic logic signed [31:0] pick_priority();
        int r;
        r = $urandom_range(99, 0);
        if (r < 30)
            return $signed($urandom_range(6, 0)) - 3;
        else if (r < 45)
        begin
            case ($urandom_range(5, 0))
                0: return PRIO_MIN;
                1: return PRIO_MAX;
                2: return PRIO_MIN + 1;
                3: return PRIO_MAX - 1;
                4: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        else
            return $urandom;
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99, 0);
        if (r < 40)
            return $urandom_range(7, 0);
        else if (r < 50)
            return ($urandom_range(1, 0) != 0) ? 32'hFFFF_FFFF : 32'h0;
        else
            return $urandom;
    endfunction

    // A query mostly aims at a stored entry, sometimes at a near miss.
    task automatic send_query();
        int                 idx;
        int                 r;
        logic [31:0]        value;
        logic signed [31:0] prio;
        r = $urandom_range(99, 0);
        if (board.stored_count > 0 && r < 70)
        begin
            idx   = $urandom_range(board.stored_count - 1, 0);
            value = board.stored_values[idx];
            prio  = board.stored_prios[idx];
            if (r >= 50)
                prio = prio + 1;
        end
        else
        begin
            value = pick_value();
            prio  = pick_priority();
        end
        send_op(OP_CONTAINS, value, prio);
    endtask

    // One random operation, weighted by the kind of burst.
    task automatic send_random_op(burst_kind_t kind);
        int r;
        int ins_pct, pop_pct, qry_pct;
        r = $urandom_range(99, 0);
        case (kind)
            BURST_FILL:  begin ins_pct = 90; pop_pct = 2;  qry_pct = 6;  end
            BURST_DRAIN: begin ins_pct = 10; pop_pct = 70; qry_pct = 15; end
            default:     begin ins_pct = 40; pop_pct = 30; qry_pct = 25; end
        endcase
        if (r < ins_pct)
            send_op(OP_INSERT, pick_value(), pick_priority());
        else if (r < ins_pct + pop_pct)
            send_op(OP_POP, $urandom, $urandom);
        else if (r < ins_pct + pop_pct + qry_pct)
            send_query();
        else
            send_op(OP_NOP, $urandom, $urandom);
    endtask

    // Main sequence.
    initial
    begin
        burst_kind_t kind;
        int          burst_len;
        int          wait_cycles;
        board         = new();
        items_sent    = 0;
        cycle_count   = 0;
        tx_idle_pct   = 24;
        rx_idle_pct   = 78;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_NOP;
        item_value    = '0;
        item_priority = '0;
        out_ready     = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty queue, priority extremes, ties and exact-match queries.
        send_op(OP_POP,      32'h0,         32'sd0);
        send_op(OP_CONTAINS, 32'h0,         32'sd0);
        send_op(OP_NOP,      32'hFFFF_FFFF, PRIO_MIN);
        send_op(OP_INSERT,   32'h0,         PRIO_MAX);
        send_op(OP_POP,      32'h0,         32'sd0);
        send_op(OP_INSERT,   32'hFFFF_FFFF, PRIO_MIN);
        send_op(OP_INSERT,   32'h1,         32'sd5);
        send_op(OP_INSERT,   32'h2,         32'sd5);
        send_op(OP_INSERT,   32'h3,         PRIO_MAX);
        send_op(OP_CONTAINS, 32'hFFFF_FFFF, PRIO_MIN);
        send_op(OP_CONTAINS, 32'hFFFF_FFFF, PRIO_MAX);
        send_op(OP_CONTAINS, 32'h1,         32'sd5);
        send_op(OP_POP,      32'h0,         32'sd0);
        send_op(OP_POP,      32'h0,         32'sd0);
        send_op(OP_NOP,      32'h1,         32'sd5);
        send_op(OP_POP,      32'h0,         32'sd0);
        send_op(OP_POP,      32'h0,         32'sd0);
        send_op(OP_POP,      32'h0,         32'sd0);
        send_op(OP_INSERT,   32'hA5A5_A5A5, -32'sd1);
        send_op(OP_INSERT,   32'h5A5A_5A5A, 32'sd0);
        send_op(OP_CONTAINS, 32'h5A5A_5A5A, 32'sd0);
        send_op(OP_POP,      32'h0,         32'sd0);
        send_op(OP_POP,      32'h0,         32'sd0);
        hold_until_drained();

        // Random: the first burst is mostly inserts, to drive the queue toward capacity.
        kind      = BURST_FILL;
        burst_len = CAPACITY + 16;
        while (items_sent < TOTAL_ITEMS)
        begin
            for (int i = 0; i < burst_len && items_sent < TOTAL_ITEMS; i++)
                send_random_op(kind);
            if ($urandom_range(3, 0) == 0)
                hold_until_drained();
            case ($urandom_range(2, 0))
                0: kind = BURST_FILL;
                1: kind = BURST_DRAIN;
                default: kind = BURST_MIXED;
            endcase
            burst_len = $urandom_range(150, 30);
        end

        // Wind down: wait for every owed result, then watch for stray ones.
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.owed_count() != 0)
            @(posedge clk);
        wait_cycles = 0;
        while (wait_cycles < SETTLE_CYCLES)
        begin
            @(posedge clk);
            wait_cycles++;
        end

        $display("Run covered %0d transfers: %0d inserts (%0d on a full queue), %0d pops (%0d on empty),",
                 items_sent, board.n_insert, board.n_full, board.n_pop, board.n_empty_pop);
        $display("%0d contains queries (%0d hits) and %0d no-ops; %0d mismatches in %0d cycles.",
                 board.n_contains, board.n_hits, board.n_nop, board.failures, cycle_count);
        if (board.failures == 0 && board.owed_count() == 0)
            $display("** unsorted_priority_queue_core: PASSED **");
        else
            $display("** unsorted_priority_queue_core: FAILED **");
        $finish;
    end

endmodule
